@@ rtl/tdpf_pkg.sv @@
// Shared constants and types for the TCP destination port filter.
package tdpf_pkg;

    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;
    localparam int POS_W   = 7;
    localparam int PORT_W  = 16;
    localparam int CNT_W   = 5;
    localparam int LANES   = 4;   // port slots per 64-bit allowlist register
    localparam int BANKS   = 4;   // allowlist registers
    localparam int MAX_SLOTS = 16;

    localparam logic [POS_W-1:0] POS_MAX      = 7'd127;
    localparam logic [POS_W-1:0] POS_ETYPE_HI = 7'd12;
    localparam logic [POS_W-1:0] POS_ETYPE_LO = 7'd13;
    localparam logic [POS_W-1:0] POS_IHL      = 7'd14;
    localparam logic [POS_W-1:0] POS_PROTO    = 7'd23;
    // dest port sits at 14 + 4*IHL + 2
    localparam logic [POS_W-1:0] PORT_OFS     = 7'd16;
    // Ethernet + IPv4 (4*IHL) + TCP header: 14 + 20 + 4*IHL
    localparam logic [POS_W:0]   TCP_MIN_LEN  = 8'd34;

    localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
    localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;
    localparam logic [7:0] PROTO_TCP     = 8'h06;

    localparam logic [CNT_W-1:0] CNT_MAX = 5'd16;

    typedef enum logic [2:0] {
        REG_DENY_ALL   = 3'd0,
        REG_PORT_COUNT = 3'd1,
        REG_PORTS_A    = 3'd2,
        REG_PORTS_B    = 3'd3,
        REG_PORTS_C    = 3'd4,
        REG_PORTS_D    = 3'd5
    } reg_idx_t;

endpackage

@@ rtl/tcp_dest_port_filter.sv @@
// Top level: TCP destination port allowlist filter on a byte-wide frame stream.
// The verdict is registered into the output register on the frame's last accepted beat.
// Throughput: one byte beat per cycle; a beat is taken while a verdict waits to be taken,
//   as long as the consumer drains the output register in the same cycle.
// The port lookup behind the verdict is one 16-way parallel compare against the allowlist slot registers.
// Reset (aresetn, synchronous, active low) clears the config registers, the header
//   capture state and the output valid.
module tcp_dest_port_filter #(
    parameter int PORT_SLOTS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // APB-style config port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tdpf_pkg::ADDR_W-1:0]  paddr,
    input  logic [tdpf_pkg::DATA_W-1:0]  pwdata,
    output logic [tdpf_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    // frame byte stream
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_frame_byte,
    input  logic                         s_end_of_frame,
    // verdict stream
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_verdict,
    output logic                         m_verdict_last
);
    import tdpf_pkg::*;

    // ---------------------------------------------------------------
    // Config registers
    // ---------------------------------------------------------------
    logic                 deny_all_reg;
    logic [CNT_W-1:0]     port_count_reg;
    logic [PORT_W-1:0]    slot_reg [PORT_SLOTS];

    logic                 cfg_wr;
    reg_idx_t             cfg_idx;
    logic [CNT_W-1:0]     cnt_wdata;
    logic [DATA_W-1:0]    bank_word [BANKS];

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    // 8-byte register stride; low address bits are don't-care
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);
    // saturate the slot count (low 5 bits of pwdata) at 16
    assign cnt_wdata = (pwdata[CNT_W-1:0] > CNT_MAX) ? CNT_MAX : pwdata[CNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deny_all_reg   <= 1'b0;
            port_count_reg <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_DENY_ALL:   deny_all_reg   <= pwdata[0];
                REG_PORT_COUNT: port_count_reg <= cnt_wdata;
                default: ;
            endcase
        end
    end

    // Each slot lives in lane (slot % 4) of allowlist register (slot / 4).
    for (genvar g = 0; g < PORT_SLOTS; g++) begin : g_slot
        localparam logic [2:0] BANK_IDX = 3'(int'(REG_PORTS_A) + g / LANES);
        localparam int         LANE     = g % LANES;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                slot_reg[g] <= '0;
            end else if (cfg_wr && (cfg_idx == reg_idx_t'(BANK_IDX))) begin
                slot_reg[g] <= pwdata[LANE*PORT_W +: PORT_W];
            end
        end
    end

    // Read-back image of the four allowlist registers
    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            if (b * LANES + l < PORT_SLOTS) begin : g_used
                assign bank_word[b][l*PORT_W +: PORT_W] = slot_reg[b*LANES + l];
            end else begin : g_unused
                assign bank_word[b][l*PORT_W +: PORT_W] = '0;
            end
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_DENY_ALL:   prdata = {{(DATA_W-1){1'b0}}, deny_all_reg};
            REG_PORT_COUNT: prdata = {{(DATA_W-CNT_W){1'b0}}, port_count_reg};
            REG_PORTS_A:    prdata = bank_word[0];
            REG_PORTS_B:    prdata = bank_word[1];
            REG_PORTS_C:    prdata = bank_word[2];
            REG_PORTS_D:    prdata = bank_word[3];
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Header capture, one byte per accepted beat
    // ---------------------------------------------------------------
    logic               in_beat;
    logic [POS_W-1:0]   pos_reg,   pos_next;
    logic [7:0]         etype_hi_reg, etype_hi_next;
    logic               ipv4_reg,  ipv4_next;
    logic [3:0]         ihl_reg,   ihl_next;
    logic               tcp_reg,   tcp_next;
    logic [PORT_W-1:0]  port_reg,  port_next;
    logic [POS_W-1:0]   port_at;

    assign in_beat = s_valid & s_ready;
    assign port_at = PORT_OFS + {1'b0, ihl_reg, 2'b00};

    always_comb begin
        pos_next      = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 7'd1;
        etype_hi_next = etype_hi_reg;
        ipv4_next     = ipv4_reg;
        ihl_next      = ihl_reg;
        tcp_next      = tcp_reg;
        port_next     = port_reg;
        if (pos_reg == POS_ETYPE_HI) begin
            etype_hi_next = s_frame_byte;
        end
        if (pos_reg == POS_ETYPE_LO) begin
            ipv4_next = (etype_hi_reg == ETYPE_IPV4_HI) && (s_frame_byte == ETYPE_IPV4_LO);
        end
        if (pos_reg == POS_IHL) begin
            ihl_next = s_frame_byte[3:0];
        end
        if (pos_reg == POS_PROTO) begin
            tcp_next = (s_frame_byte == PROTO_TCP);
        end
        // port_at >= 16, so both bytes always lie past the IHL byte
        if (pos_reg == port_at) begin
            port_next[15:8] = s_frame_byte;
        end else if (pos_reg == port_at + 7'd1) begin
            port_next[7:0] = s_frame_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            etype_hi_reg <= '0;
            ipv4_reg     <= 1'b0;
            ihl_reg      <= '0;
            tcp_reg      <= 1'b0;
            port_reg     <= '0;
        end else if (in_beat) begin
            if (s_end_of_frame) begin
                // fresh capture for the next frame
                pos_reg      <= '0;
                etype_hi_reg <= '0;
                ipv4_reg     <= 1'b0;
                ihl_reg      <= '0;
                tcp_reg      <= 1'b0;
                port_reg     <= '0;
            end else begin
                pos_reg      <= pos_next;
                etype_hi_reg <= etype_hi_next;
                ipv4_reg     <= ipv4_next;
                ihl_reg      <= ihl_next;
                tcp_reg      <= tcp_next;
                port_reg     <= port_next;
            end
        end
    end

    // ---------------------------------------------------------------
    // Verdict on the last beat.
    // Any frame long enough to pass the length check has all header
    // fields captured before its last byte, so the registered copies
    // are final here.
    // ---------------------------------------------------------------
    logic [POS_W:0]     frame_len;
    logic [POS_W:0]     need_len;
    logic               too_short;
    logic [PORT_SLOTS-1:0] slot_hit;
    logic               port_listed;
    logic               verdict_next;

    assign frame_len = {1'b0, pos_reg} + 8'd1;
    assign need_len  = TCP_MIN_LEN + {2'b00, ihl_reg, 2'b00};
    assign too_short = frame_len < need_len;

    for (genvar g = 0; g < PORT_SLOTS; g++) begin : g_cmp
        assign slot_hit[g] = (CNT_W'(g) < port_count_reg) && (slot_reg[g] == port_reg);
    end
    assign port_listed = |slot_hit;

    assign verdict_next = ipv4_reg & tcp_reg & ~too_short & (deny_all_reg | ~port_listed);

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic m_valid_reg;
    logic m_verdict_reg;

    assign s_ready        = ~m_valid_reg | m_ready;
    assign m_valid        = m_valid_reg;
    assign m_verdict      = m_verdict_reg;
    assign m_verdict_last = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_beat && s_end_of_frame) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat && s_end_of_frame) begin
            m_verdict_reg <= verdict_next;
        end
    end

endmodule

@@ rtl/tdpf_checker.sv @@
// Port-level assertions for the TCP destination port filter, bound to the top level.
module tdpf_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [tdpf_pkg::ADDR_W-1:0]  paddr,
    input logic [tdpf_pkg::DATA_W-1:0]  pwdata,
    input logic [tdpf_pkg::DATA_W-1:0]  prdata,
    input logic                         pready,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic [7:0]                   s_frame_byte,
    input logic                         s_end_of_frame,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_verdict,
    input logic                         m_verdict_last
);
    import tdpf_pkg::*;

    // last beat of a frame always yields a verdict next cycle
    a_eof_gives_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_end_of_frame |=> m_valid)
        else $error("no verdict after last beat");

    // a mid-frame beat with the output drained leaves no verdict behind
    a_no_spurious_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_end_of_frame && (!m_valid || m_ready) |=> !m_valid)
        else $error("verdict without last beat");

    // a stalled verdict holds its value
    a_verdict_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_verdict))
        else $error("stalled verdict changed");

    // every verdict closes a frame
    a_last_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_verdict_last)
        else $error("verdict without last mark");

endmodule

bind tcp_dest_port_filter tdpf_checker u_tdpf_checker (.*);
